FILE: rtl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the framed command decoder: framing
// characters, command and event codes, and the keyword table.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_START = 8'h2A;

    // longest keyword; only this many leading bytes of a command are kept
    localparam int KEY_MAX  = 7;
    localparam int NUM_KEYS = 7;

    localparam logic [7:0] MOTOR_HALF = 8'd127;
    localparam logic [7:0] MOTOR_FULL = 8'd255;

    typedef logic [0:KEY_MAX-1][7:0] text_t;

    typedef enum logic [2:0] {
        CMD_INVALID  = 3'd0,
        CMD_LED_ON   = 3'd1,
        CMD_LED_OFF  = 3'd2,
        CMD_HALF     = 3'd3,
        CMD_FULL     = 3'd4,
        CMD_OPEN     = 3'd5,
        CMD_CLOSE    = 3'd6,
        CMD_STATUS   = 3'd7
    } cmd_code_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DONE     = 2'd1,
        EV_TOO_LONG = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        LVL_NONE = 2'd0,
        LVL_COOL = 2'd1,
        LVL_WARM = 2'd2,
        LVL_HOT  = 2'd3
    } temp_level_t;

    // view of the command buffer handed to the keyword matcher
    typedef struct packed {
        logic        valid;
        logic [2:0]  len;
        text_t       text;
    } text_view_t;

    // keyword text, first character at index 0, zero padded
    localparam text_t KEY_TEXT [NUM_KEYS] = '{
        {"LED_ON",  8'h00},
        {"LED_OFF"},
        {"MS_50",   16'h0000},
        {"MS_100",  8'h00},
        {"D_OP",    24'h000000},
        {"D_CL",    24'h000000},
        {"SC",      40'h0000000000}
    };

    localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{
        3'd6, 3'd7, 3'd5, 3'd6, 3'd4, 3'd4, 3'd2
    };

endpackage

FILE: rtl/fcd_match.sv
// ----------------------------------------------------------------------------
// fcd_match
// Compares the buffered command text against the keyword table and returns
// the command code of the matching keyword, or the invalid code.
// ----------------------------------------------------------------------------
module fcd_match (
    input  fcd_pkg::text_view_t view,
    output fcd_pkg::cmd_code_t  code
);

    logic [fcd_pkg::NUM_KEYS-1:0] hit;

    // length and content must both agree
    always_comb
    begin
        for (int k = 0; k < fcd_pkg::NUM_KEYS; k++)
        begin
            hit[k] = view.valid && (view.len == fcd_pkg::KEY_LEN[k]);
            for (int i = 0; i < fcd_pkg::KEY_MAX; i++)
            begin
                if ((i < int'(fcd_pkg::KEY_LEN[k]))
                    && (view.text[i] != fcd_pkg::KEY_TEXT[k][i]))
                begin
                    hit[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        code = fcd_pkg::CMD_INVALID;
        for (int k = fcd_pkg::NUM_KEYS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                code = fcd_pkg::cmd_code_t'(3'(k + 1));
            end
        end
    end

endmodule

FILE: rtl/framed_command_decoder.sv
// ----------------------------------------------------------------------------
// framed_command_decoder
// Serial command decoder: echoes bytes, frames commands with '*' and '#',
// decodes keywords into LED, motor, door and temperature status outputs.
// ----------------------------------------------------------------------------
// One received byte enters per clock and its result appears on the master
// side in the next cycle, held in a single result register; a new byte is
// taken whenever that register is empty or is being drained in the same
// cycle, so the sustained rate is one byte per cycle. A '#' is decoded in
// the cycle it arrives. Only the first seven command bytes are stored, as
// no keyword is longer; the fill count still runs up to MAX_TEXT-1 before
// a too-long event. The user must write the temperature thresholds over the
// APB port only while no transfer is in flight; the block does not enforce it.
module framed_command_decoder #(
    parameter int MAX_TEXT = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side, s_tdata: rx_byte[7:0], adc_sample[17:8], zero [23:18]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // master side, m_tdata: echo_byte[7:0], blue_led_on[8], door_open[9],
    // motor_compare[17:10], temp_level[19:18], reported_sample[29:20], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // m_tuser: event_kind[1:0], command_code[4:2]
    output logic [4:0]  m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FILL_W = $clog2(MAX_TEXT);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(MAX_TEXT - 1);
    localparam logic [FILL_W-1:0] KEEP_MAX  = FILL_W'(fcd_pkg::KEY_MAX);

    // configuration registers
    logic [9:0] cool_max_reg;
    logic [9:0] warm_max_reg;

    // decoder state
    fcd_pkg::text_t       text_reg, text_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 blue_reg, blue_next;
    logic                 door_reg, door_next;
    logic [7:0]           speed_reg, speed_next;
    fcd_pkg::temp_level_t level_reg, level_next;
    logic [9:0]           sample_reg, sample_next;

    // result register
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic [4:0]  m_user_reg;

    logic                 s_fire;
    logic [7:0]           rx_byte;
    logic [9:0]           adc_sample;
    fcd_pkg::text_view_t  view;
    fcd_pkg::cmd_code_t   match_code;
    fcd_pkg::cmd_code_t   code;
    fcd_pkg::event_kind_t ev;

    assign rx_byte    = s_tdata[7:0];
    assign adc_sample = s_tdata[17:8];
    assign s_tready   = !m_valid_reg || m_tready;
    assign s_fire     = s_tvalid && s_tready;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {22'd0, warm_max_reg} : {22'd0, cool_max_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cool_max_reg <= 10'd53;
            warm_max_reg <= 10'd73;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2])
            begin
                warm_max_reg <= pwdata[9:0];
            end
            else
            begin
                cool_max_reg <= pwdata[9:0];
            end
        end
    end

    // ---------------- keyword match ----------------
    assign view.valid = (fill_reg >> 3) == '0;
    assign view.len   = fill_reg[2:0];
    assign view.text  = text_reg;

    fcd_match u_match (
        .view (view),
        .code (match_code)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        text_next   = text_reg;
        fill_next   = fill_reg;
        blue_next   = blue_reg;
        door_next   = door_reg;
        speed_next  = speed_reg;
        level_next  = level_reg;
        sample_next = sample_reg;
        ev          = fcd_pkg::EV_NONE;
        code        = fcd_pkg::CMD_INVALID;

        if (rx_byte == fcd_pkg::CH_END)
        begin
            ev        = fcd_pkg::EV_DONE;
            code      = match_code;
            fill_next = '0;
            unique case (match_code)
                fcd_pkg::CMD_LED_ON:  blue_next  = 1'b1;
                fcd_pkg::CMD_LED_OFF: blue_next  = 1'b0;
                fcd_pkg::CMD_HALF:    speed_next = fcd_pkg::MOTOR_HALF;
                fcd_pkg::CMD_FULL:    speed_next = fcd_pkg::MOTOR_FULL;
                fcd_pkg::CMD_OPEN:    door_next  = 1'b1;
                fcd_pkg::CMD_CLOSE:   door_next  = 1'b0;
                fcd_pkg::CMD_STATUS:
                begin
                    sample_next = adc_sample;
                    // cool is tested first, whatever the threshold order
                    if (adc_sample <= cool_max_reg)
                    begin
                        level_next = fcd_pkg::LVL_COOL;
                    end
                    else if (adc_sample <= warm_max_reg)
                    begin
                        level_next = fcd_pkg::LVL_WARM;
                    end
                    else
                    begin
                        level_next = fcd_pkg::LVL_HOT;
                    end
                end
                default: ;
            endcase
        end
        else if (rx_byte == fcd_pkg::CH_START)
        begin
            fill_next = '0;
        end
        else if (fill_reg < FILL_LAST)
        begin
            // bytes beyond the longest keyword only advance the count
            if (fill_reg < KEEP_MAX)
            begin
                text_next[fill_reg[2:0]] = rx_byte;
            end
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            fill_next = '0;
            ev        = fcd_pkg::EV_TOO_LONG;
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            blue_reg   <= 1'b0;
            door_reg   <= 1'b0;
            speed_reg  <= '0;
            level_reg  <= fcd_pkg::LVL_NONE;
            sample_reg <= '0;
        end
        else if (s_fire)
        begin
            fill_reg   <= fill_next;
            blue_reg   <= blue_next;
            door_reg   <= door_next;
            speed_reg  <= speed_next;
            level_reg  <= level_next;
            sample_reg <= sample_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            text_reg <= text_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            m_data_reg <= {2'b00, sample_next, level_next, speed_next,
                           door_next, blue_next, rx_byte};
            m_user_reg <= {code, ev};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---------------- assertions ----------------
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_LAST)
        else $error("fill count beyond buffer size");

    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && ((rx_byte == fcd_pkg::CH_END) || (rx_byte == fcd_pkg::CH_START))
        |=> fill_reg == '0)
        else $error("framing byte did not empty the buffer");

    a_code_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] != fcd_pkg::EV_DONE) |-> m_tuser[4:2] == 3'd0)
        else $error("command code without completed command");

    a_motor_values: assert property (@(posedge clk) disable iff (!rst_n)
        (speed_reg == 8'd0) || (speed_reg == fcd_pkg::MOTOR_HALF)
        || (speed_reg == fcd_pkg::MOTOR_FULL))
        else $error("unexpected motor compare value");

    a_accept_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framed command decoder. A scoreboard model
// tracks the command buffer, LED, door, motor and temperature state and
// checks every master-side transfer against it. A directed table is run
// first, then random framed commands, noise and over-long runs under
// several threshold settings, with random idling on both sides and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int MAX_TEXT     = 20;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 340;
    localparam int QUIET_ITEMS  = 200;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int N_DIRECTED   = 25;

    localparam logic [2:0] REG_COOL_ADDR = 3'd0;
    localparam logic [2:0] REG_WARM_ADDR = 3'd4;

    // keyword spellings, first character in the highest used byte
    localparam logic [55:0] KEYWORDS [7] = '{
        "LED_ON", "LED_OFF", "MS_50", "MS_100", "D_OP", "D_CL", "SC"
    };
    localparam int KEY_LENS [7] = '{6, 7, 5, 6, 4, 4, 2};

    typedef struct {
        logic [7:0]           echo;
        fcd_pkg::event_kind_t ev;
        fcd_pkg::cmd_code_t   code;
        logic                 blue;
        logic                 door;
        logic [7:0]           motor;
        fcd_pkg::temp_level_t lvl;
        logic [9:0]           smp;
    } reply_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [9:0] smp;
        logic       typed;
        logic [1:0] ev;
        logic [2:0] code;
    } row_t;

    // typed event and command only where obvious; all other fields predicted
    localparam row_t DIRECTED [N_DIRECTED] = '{
        {fcd_pkg::CH_END,   10'd0,    1'b1, fcd_pkg::EV_DONE, fcd_pkg::CMD_INVALID},
        {"L",               10'd0,    1'b1, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"E",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"D",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"_",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"O",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"N",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {fcd_pkg::CH_END,   10'd0,    1'b1, fcd_pkg::EV_DONE, fcd_pkg::CMD_LED_ON},
        {"S",               10'd1023, 1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"C",               10'd1023, 1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {fcd_pkg::CH_END,   10'd1023, 1'b1, fcd_pkg::EV_DONE, fcd_pkg::CMD_STATUS},
        {"S",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"C",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {fcd_pkg::CH_END,   10'd0,    1'b1, fcd_pkg::EV_DONE, fcd_pkg::CMD_STATUS},
        {fcd_pkg::CH_START, 10'd0,    1'b1, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {8'h00,             10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {8'hFF,             10'd1023, 1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {fcd_pkg::CH_END,   10'd0,    1'b1, fcd_pkg::EV_DONE, fcd_pkg::CMD_INVALID},
        {"D",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"_",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"O",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {"P",               10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {fcd_pkg::CH_END,   10'd0,    1'b1, fcd_pkg::EV_DONE, fcd_pkg::CMD_OPEN},
        {fcd_pkg::CH_START, 10'd0,    1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID},
        {fcd_pkg::CH_END,   10'd0,    1'b1, fcd_pkg::EV_DONE, fcd_pkg::CMD_INVALID}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // rx_byte[7:0], adc_sample[17:8], zero [23:18]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // echo_byte[7:0], blue_led_on[8], door_open[9],
                            // motor_compare[17:10], temp_level[19:18],
                            // reported_sample[29:20], zero [31:30]
    logic [4:0]  m_tuser;   // event_kind[1:0], command_code[4:2]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // scoreboard state
    logic [7:0]           cmd_text [MAX_TEXT-1];
    int                   cmd_len;
    logic                 led_lit;
    logic                 door_is_open;
    logic [7:0]           motor_level;
    fcd_pkg::temp_level_t heat_level;
    logic [9:0]           status_sample;
    logic [9:0]           cool_limit;
    logic [9:0]           warm_limit;

    reply_t      pending_replies [$];
    int          err_count;
    int          item_count;
    int          cycle_count;
    bit          quiet;
    bit          hold_request;

    framed_command_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [7:0] key_char(input int k, input int i);
        key_char = KEYWORDS[k][(KEY_LENS[k] - 1 - i) * 8 +: 8];
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == fcd_pkg::CH_END || b == fcd_pkg::CH_START);
        return b;
    endfunction

    // half of the time around the thresholds so the compare edges get hit
    function automatic logic [9:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            return cool_limit + 10'($urandom_range(0, 2)) - 10'd1;
        else if (sel == 1)
            return warm_limit + 10'($urandom_range(0, 2)) - 10'd1;
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic reply_t decode_byte(input logic [7:0] b, input logic [9:0] smp);
        reply_t r;
        int     k;
        int     i;
        bit     hit;
        r.echo = b;
        r.ev   = fcd_pkg::EV_NONE;
        r.code = fcd_pkg::CMD_INVALID;
        if (b == fcd_pkg::CH_END)
        begin
            r.ev = fcd_pkg::EV_DONE;
            for (k = 0; k < 7; k++)
            begin
                if (r.code == fcd_pkg::CMD_INVALID && cmd_len == KEY_LENS[k])
                begin
                    hit = 1'b1;
                    for (i = 0; i < KEY_LENS[k]; i++)
                        if (cmd_text[i] !== key_char(k, i))
                            hit = 1'b0;
                    if (hit)
                        r.code = fcd_pkg::cmd_code_t'(k + 1);
                end
            end
            case (r.code)
                fcd_pkg::CMD_LED_ON:  led_lit = 1'b1;
                fcd_pkg::CMD_LED_OFF: led_lit = 1'b0;
                fcd_pkg::CMD_HALF:    motor_level = 8'd127;
                fcd_pkg::CMD_FULL:    motor_level = 8'd255;
                fcd_pkg::CMD_OPEN:    door_is_open = 1'b1;
                fcd_pkg::CMD_CLOSE:   door_is_open = 1'b0;
                fcd_pkg::CMD_STATUS:
                begin
                    status_sample = smp;
                    // cool is tested first even if the limits are swapped
                    if (smp <= cool_limit)
                        heat_level = fcd_pkg::LVL_COOL;
                    else if (smp <= warm_limit)
                        heat_level = fcd_pkg::LVL_WARM;
                    else
                        heat_level = fcd_pkg::LVL_HOT;
                end
                default: ;
            endcase
            cmd_len = 0;
        end
        else if (b == fcd_pkg::CH_START)
            cmd_len = 0;
        else if (cmd_len < MAX_TEXT - 1)
        begin
            cmd_text[cmd_len] = b;
            cmd_len++;
        end
        else
        begin
            cmd_len = 0;
            r.ev    = fcd_pkg::EV_TOO_LONG;
        end
        r.blue  = led_lit;
        r.door  = door_is_open;
        r.motor = motor_level;
        r.lvl   = heat_level;
        r.smp   = status_sample;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    // handshake decided from values that are stable at the falling edge
    always @(negedge clk)
    begin
        reply_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("transfer with no reply waiting, echo_byte %0d", m_tdata[7:0]);
                err_count++;
            end
            else
            begin
                e = pending_replies.pop_front();
                check_field("echo_byte", e.echo, m_tdata[7:0]);
                check_field("event_kind", e.ev, m_tuser[1:0]);
                check_field("command_code", e.code, m_tuser[4:2]);
                check_field("blue_led_on", e.blue, m_tdata[8]);
                check_field("door_open", e.door, m_tdata[9]);
                check_field("motor_compare", e.motor, m_tdata[17:10]);
                check_field("temp_level", e.lvl, m_tdata[19:18]);
                check_field("reported_sample", e.smp, m_tdata[29:20]);
            end
        end
    end

    initial
    begin : sink_ready
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                // long hold-off so the block backs up into its input
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic [9:0] smp, input bit typed,
                             input logic [1:0] t_ev, input logic [2:0] t_code);
        int     gap;
        bit     taken;
        reply_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, smp, b};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        r = decode_byte(b, smp);
        if (typed)
        begin
            r.ev   = fcd_pkg::event_kind_t'(t_ev);
            r.code = fcd_pkg::cmd_code_t'(t_code);
        end
        pending_replies.push_back(r);
        item_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [9:0] smp);
        send_item(b, smp, 1'b0, fcd_pkg::EV_NONE, fcd_pkg::CMD_INVALID);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [9:0] value);
        bit rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {22'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end
        while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_COOL_ADDR)
            cool_limit = value;
        else
            warm_limit = value;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int         p;
        int         r;
        int         j;
        int         k;
        int         n;
        int         phase_end;
        int         bad_pos;
        logic [9:0] cool_set;
        logic [9:0] warm_set;
        logic [7:0] ch;

        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cmd_len       = 0;
        led_lit       = 1'b0;
        door_is_open  = 1'b0;
        motor_level   = 8'd0;
        heat_level    = fcd_pkg::LVL_NONE;
        status_sample = 10'd0;
        cool_limit    = 10'd53;
        warm_limit    = 10'd73;
        err_count     = 0;
        item_count    = 0;
        cycle_count   = 0;
        quiet         = 1'b0;
        hold_request  = 1'b0;
        rst_n         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < N_DIRECTED; r++)
            send_item(DIRECTED[r].ch, DIRECTED[r].smp, DIRECTED[r].typed,
                      DIRECTED[r].ev, DIRECTED[r].code);
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin cool_set = 10'd53;   warm_set = 10'd73;   end
                1:       begin cool_set = 10'd0;    warm_set = 10'd0;    end
                2:       begin cool_set = 10'd1023; warm_set = 10'd1023; end
                3:       begin cool_set = 10'd1023; warm_set = 10'd0;    end
                default:
                begin
                    cool_set = 10'($urandom_range(0, 1023));
                    warm_set = 10'($urandom_range(0, 1023));
                end
            endcase
            apb_write(REG_COOL_ADDR, cool_set);
            apb_write(REG_WARM_ADDR, warm_set);
            if (p == 2)
                hold_request = 1'b1;
            phase_end = item_count + PHASE_ITEMS;
            while (item_count < phase_end)
            begin
                if (p == NUM_PHASES - 1 && item_count >= phase_end - QUIET_ITEMS)
                    quiet = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    // framed keyword, now and then with one character spoiled
                    if ($urandom_range(0, 1))
                        send_byte(fcd_pkg::CH_START, pick_sample());
                    k = $urandom_range(0, 6);
                    bad_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, KEY_LENS[k] - 1)
                                                          : -1;
                    for (j = 0; j < KEY_LENS[k]; j++)
                    begin
                        ch = key_char(k, j);
                        if (j == bad_pos)
                            ch = plain_byte();
                        send_byte(ch, pick_sample());
                    end
                    send_byte(fcd_pkg::CH_END, pick_sample());
                end
                else if (r < 70)
                begin
                    n = $urandom_range(0, 8);
                    for (j = 0; j < n; j++)
                        send_byte(plain_byte(), pick_sample());
                    send_byte(fcd_pkg::CH_END, pick_sample());
                end
                else if (r < 80)
                begin
                    // run up to or past the buffer limit
                    send_byte(fcd_pkg::CH_START, pick_sample());
                    n = $urandom_range(MAX_TEXT - 1, MAX_TEXT + 4);
                    for (j = 0; j < n; j++)
                        send_byte(plain_byte(), pick_sample());
                    if ($urandom_range(0, 1))
                        send_byte(fcd_pkg::CH_END, pick_sample());
                end
                else
                    send_byte(8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
